// ===== hw/rtl/slm_pkg.sv =====
// Shared types, constants and helpers for the P.56 sound level meter.
// Used by every module of the meter; depends on nothing.
package slm_pkg;

  localparam int SAMPLE_W       = 24;
  localparam int LEVEL_W        = 47;
  localparam int ENV_W          = 48;
  localparam int SUM_W          = 57;
  localparam int ENERGY_W       = 63;
  localparam int WORD_W         = 32;
  localparam int STEP_LEN_W     = 11;
  localparam int STEP_CNT_W     = 10;
  localparam int COEF_W         = 24;
  localparam int HANG_W         = 10;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 24;
  localparam int COEF_FRAC_BITS = 24;
  localparam int MAC_W          = 50;
  localparam int MAX_STEP_LEN   = 1024;
  localparam int NUM_THRESHOLDS_DEF = 29;
  localparam int Q_DEPTH        = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_LEN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENV_COEF  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_COEF = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_COEF = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RISE_COEF = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FALL_COEF = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_HANGOVER  = 3'd6;

  localparam logic [STEP_LEN_W-1:0] RST_STEP_LEN  = 11'd48;
  localparam logic [COEF_W-1:0]     RST_ENV_COEF  = 24'd16765573;
  localparam logic [COEF_W-1:0]     RST_FAST_COEF = 24'd133685;
  localparam logic [COEF_W-1:0]     RST_SLOW_COEF = 24'd16769;
  localparam logic [COEF_W-1:0]     RST_RISE_COEF = 24'd472548;
  localparam logic [COEF_W-1:0]     RST_FALL_COEF = 24'd11180;
  localparam logic [HANG_W-1:0]     RST_HANGOVER  = 10'd200;

  // result kinds
  localparam logic [1:0] KIND_STEP    = 2'd0;
  localparam logic [1:0] KIND_COUNT   = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       end_of_track;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic                last;
    logic [LEVEL_W-1:0]  peak_sq;
    logic [LEVEL_W-1:0]  mean_sq;
    logic [LEVEL_W-1:0]  envelope_sq;
    logic [LEVEL_W-1:0]  fast_level;
    logic [LEVEL_W-1:0]  slow_level;
    logic [LEVEL_W-1:0]  impulse_level;
    logic [WORD_W-1:0]   index;
    logic [WORD_W-1:0]   over_count;
    logic [ENERGY_W-1:0] total_energy;
  } out_item_t;

  typedef struct packed {
    logic [STEP_LEN_W-1:0] len;
    logic [COEF_W-1:0]     env_coef;
    logic [COEF_W-1:0]     fast_coef;
    logic [COEF_W-1:0]     slow_coef;
    logic [COEF_W-1:0]     rise_coef;
    logic [COEF_W-1:0]     fall_coef;
    logic [HANG_W-1:0]     hangover;
  } cfg_t;

  // one request from the front to the back
  typedef struct packed {
    logic                  has_step;
    logic                  eot;
    logic [LEVEL_W-1:0]    block_peak;
    logic [SUM_W-1:0]      square_sum;
    logic [ENV_W-1:0]      env_out;
    logic [STEP_LEN_W-1:0] len;
    logic [LEVEL_W-1:0]    overall_peak;
  } q_entry_t;

  typedef enum logic [2:0] {
    F_IDLE, F_SQ, F_MID_A, F_MID_B, F_OUT_A, F_OUT_B, F_PUSH
  } front_state_t;

  typedef enum logic [3:0] {
    B_IDLE, B_DIV, B_ESQ, B_THR, B_FAST_X, B_FAST_R, B_SLOW_X, B_SLOW_R,
    B_RISE_X, B_RISE_R, B_IMP, B_STEP_OUT, B_CNT_OUT, B_SUM_OUT
  } back_state_t;

  function automatic logic [COEF_W:0] coef_b(input logic [COEF_W-1:0] c);
    coef_b = (COEF_W+1)'(1 << COEF_FRAC_BITS) - {1'b0, c};
  endfunction

  function automatic logic [LEVEL_W-1:0] sat47(input logic [MAC_W:0] x);
    sat47 = (x > (MAC_W+1)'({LEVEL_W{1'b1}})) ? {LEVEL_W{1'b1}} : x[LEVEL_W-1:0];
  endfunction

  function automatic logic [ENV_W-1:0] sat48(input logic [MAC_W:0] x);
    sat48 = (x > (MAC_W+1)'({ENV_W{1'b1}})) ? {ENV_W{1'b1}} : x[ENV_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/slm_mac.sv =====
// Multi-cycle rounded product round(v * c / 2^24), saturated to MAC_W bits.
// One 24x25 multiplier walks three 24-bit digits of v. Depends on slm_pkg.
module slm_mac (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [slm_pkg::SUM_W-1:0]       v,
  input  logic [slm_pkg::COEF_W:0]        c,
  output logic                            done,
  output logic [slm_pkg::MAC_W-1:0]       res
);

  logic                            busy;
  logic [1:0]                      ph;
  logic [slm_pkg::SUM_W-1:0]       vr;
  logic [slm_pkg::COEF_W:0]        cr;
  logic [48:0]                     prod;
  logic [23:0]                     digit;
  logic [57:0]                     top_sum;

  always_comb begin
    unique case (ph)
      2'd0:    digit = vr[23:0];
      2'd1:    digit = vr[47:24];
      default: digit = {15'd0, vr[56:48]};
    endcase
    top_sum = {8'd0, res} + {prod[33:0], 24'd0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      ph   <= 2'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        vr   <= v;
        cr   <= c;
        ph   <= 2'd0;
        busy <= 1'b1;
      end else if (busy) begin
        prod <= digit * cr;
        ph   <= ph + 2'd1;
        unique case (ph)
          2'd0: res <= '0;
          2'd1: res <= slm_pkg::MAC_W'((prod + 49'(1 << 23)) >> 24);
          2'd2: res <= res + slm_pkg::MAC_W'(prod);
          default: begin
            // top digit adds at 2^24, clamp
            res  <= (top_sum[57:50] != '0) ? '1 : top_sum[49:0];
            busy <= 1'b0;
            done <= 1'b1;
          end
        endcase
      end
    end
  end

endmodule

// ===== hw/rtl/slm_fifo.sv =====
// Short request queue between the front and the back of the meter.
// Holds slm_pkg::q_entry_t requests; depends on slm_pkg.
module slm_fifo #(
  parameter int DEPTH = slm_pkg::Q_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  slm_pkg::q_entry_t push_data,
  output logic              full,
  input  logic              pop,
  output slm_pkg::q_entry_t pop_data,
  output logic              empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  slm_pkg::q_entry_t mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        mem[wr_ptr] <= push_data;
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/slm_front.sv =====
// Front of the meter: takes samples, squares them, runs the two-pole envelope
// and block sums, and queues a request per finished block or end of track.
// Depends on slm_pkg and slm_mac.
module slm_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  slm_pkg::in_item_t in_data,
  input  slm_pkg::cfg_t     cfg,
  output logic              push,
  output slm_pkg::q_entry_t push_data,
  input  logic              q_full
);

  slm_pkg::front_state_t st, st_next;

  logic [slm_pkg::SAMPLE_W-1:0]   mag;
  logic                           eot_r;
  logic [slm_pkg::STEP_CNT_W-1:0] step_cnt;
  logic [slm_pkg::SUM_W-1:0]      square_sum;
  logic [slm_pkg::LEVEL_W-1:0]    block_peak;
  logic [slm_pkg::LEVEL_W-1:0]    overall_peak;
  logic [slm_pkg::ENV_W-1:0]      env_mid;
  logic [slm_pkg::ENV_W-1:0]      env_out;
  logic [slm_pkg::MAC_W-1:0]      tmp;
  logic                           mac_pend;

  logic                           mac_start;
  logic [slm_pkg::SUM_W-1:0]      mac_v;
  logic [slm_pkg::COEF_W:0]       mac_c;
  logic                           mac_done;
  logic [slm_pkg::MAC_W-1:0]      mac_res;
  logic [slm_pkg::MAC_W:0]        env_sum;
  logic [slm_pkg::LEVEL_W-1:0]    sq;
  logic [slm_pkg::STEP_LEN_W-1:0] cnt_inc;
  logic                           step_done;
  logic [slm_pkg::SAMPLE_W-1:0]   neg_sample;

  assign neg_sample = ~in_data.sample + 24'd1;
  assign sq         = slm_pkg::LEVEL_W'(mag * mag);
  assign cnt_inc    = {1'b0, step_cnt} + 11'd1;
  assign step_done  = (cnt_inc >= cfg.len);
  assign env_sum    = {1'b0, tmp} + {1'b0, mac_res};

  assign push_data.has_step     = step_done;
  assign push_data.eot          = eot_r;
  assign push_data.block_peak   = block_peak;
  assign push_data.square_sum   = square_sum;
  assign push_data.env_out      = env_out;
  assign push_data.len          = cfg.len;
  assign push_data.overall_peak = overall_peak;

  slm_mac u_mac (
    .clk   (clk),
    .rst   (rst),
    .start (mac_start),
    .v     (mac_v),
    .c     (mac_c),
    .done  (mac_done),
    .res   (mac_res)
  );

  always_comb begin
    st_next   = st;
    in_ready  = 1'b0;
    push      = 1'b0;
    mac_start = 1'b0;
    mac_v     = {9'd0, env_mid};
    mac_c     = {1'b0, cfg.env_coef};
    unique case (st)
      slm_pkg::F_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) st_next = slm_pkg::F_SQ;
      end
      slm_pkg::F_SQ: st_next = slm_pkg::F_MID_A;
      slm_pkg::F_MID_A: begin
        mac_start = !mac_pend;
        if (mac_done) st_next = slm_pkg::F_MID_B;
      end
      slm_pkg::F_MID_B: begin
        // exact mag * B: the low digit is zero
        mac_v     = {9'd0, mag, 24'd0};
        mac_c     = slm_pkg::coef_b(cfg.env_coef);
        mac_start = !mac_pend;
        if (mac_done) st_next = slm_pkg::F_OUT_A;
      end
      slm_pkg::F_OUT_A: begin
        mac_v     = {9'd0, env_out};
        mac_start = !mac_pend;
        if (mac_done) st_next = slm_pkg::F_OUT_B;
      end
      slm_pkg::F_OUT_B: begin
        mac_c     = slm_pkg::coef_b(cfg.env_coef);
        mac_start = !mac_pend;
        if (mac_done) st_next = slm_pkg::F_PUSH;
      end
      slm_pkg::F_PUSH: begin
        if (!((step_done || eot_r) && q_full)) begin
          push    = step_done || eot_r;
          st_next = slm_pkg::F_IDLE;
        end
      end
      default: st_next = slm_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= slm_pkg::F_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mac_pend     <= 1'b0;
      step_cnt     <= '0;
      square_sum   <= '0;
      block_peak   <= '0;
      overall_peak <= '0;
      env_mid      <= '0;
      env_out      <= '0;
    end else begin
      if (mac_start) mac_pend <= 1'b1;
      if (mac_done)  mac_pend <= 1'b0;
      unique case (st)
        slm_pkg::F_IDLE: begin
          if (in_valid) begin
            mag   <= in_data.sample[slm_pkg::SAMPLE_W-1] ? neg_sample : in_data.sample;
            eot_r <= in_data.end_of_track;
          end
        end
        slm_pkg::F_SQ: begin
          square_sum <= square_sum + slm_pkg::SUM_W'(sq);
          if (sq > block_peak)   block_peak   <= sq;
          if (sq > overall_peak) overall_peak <= sq;
        end
        slm_pkg::F_MID_A, slm_pkg::F_OUT_A: begin
          if (mac_done) tmp <= mac_res;
        end
        slm_pkg::F_MID_B: begin
          if (mac_done) env_mid <= slm_pkg::sat48(env_sum);
        end
        slm_pkg::F_OUT_B: begin
          if (mac_done) env_out <= slm_pkg::sat48(env_sum);
        end
        slm_pkg::F_PUSH: begin
          if (st_next == slm_pkg::F_IDLE) begin
            if (step_done || eot_r) begin
              step_cnt   <= '0;
              square_sum <= '0;
              block_peak <= '0;
            end else begin
              step_cnt <= cnt_inc[slm_pkg::STEP_CNT_W-1:0];
            end
            if (eot_r) begin
              overall_peak <= '0;
              env_mid      <= '0;
              env_out      <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/slm_back.sv =====
// Back of the meter: per block divides for the mean square, squares the
// envelope, updates activity counters and Fast/Slow/Impulse levels, and
// drives the result register. Depends on slm_pkg and slm_mac.
module slm_back #(
  parameter int NUM_THRESHOLDS = slm_pkg::NUM_THRESHOLDS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  slm_pkg::cfg_t      cfg,
  input  logic               q_empty,
  input  slm_pkg::q_entry_t  pop_data,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output slm_pkg::out_item_t out_data
);

  localparam int IDX_W = (NUM_THRESHOLDS > 1) ? $clog2(NUM_THRESHOLDS) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_THRESHOLDS - 1);

  slm_pkg::back_state_t st, st_next;

  slm_pkg::q_entry_t             e;
  logic [slm_pkg::SUM_W-1:0]     ms;
  logic [slm_pkg::STEP_LEN_W-1:0] div_rem;
  logic [5:0]                    div_cnt;
  logic [95:0]                   sq96;
  logic [1:0]                    esq_ph;
  logic [47:0]                   mprod;
  logic [IDX_W-1:0]              thr_idx;
  logic                          any_hi;
  logic                          mac_pend;
  logic [slm_pkg::MAC_W-1:0]     tmp;
  logic [slm_pkg::LEVEL_W-1:0]   fast_run, slow_run, rise_run, imp_run;
  logic [slm_pkg::LEVEL_W-1:0]   fast_peak, slow_peak, imp_peak;
  logic [slm_pkg::SUM_W-1:0]     mean_peak;
  logic [slm_pkg::WORD_W-1:0]    fast_peak_step, step_number;
  logic [slm_pkg::ENERGY_W-1:0]  energy;
  logic [slm_pkg::WORD_W-1:0]    active [NUM_THRESHOLDS];
  logic [slm_pkg::HANG_W-1:0]    hang   [NUM_THRESHOLDS];

  logic                          mac_start;
  logic [slm_pkg::SUM_W-1:0]     mac_v;
  logic [slm_pkg::COEF_W:0]      mac_c;
  logic                          mac_done;
  logic [slm_pkg::MAC_W-1:0]     mac_res;
  logic [slm_pkg::MAC_W:0]       lvl_sum;
  logic [slm_pkg::LEVEL_W-1:0]   lvl_new;
  logic [slm_pkg::LEVEL_W-1:0]   imp_new;
  logic                          out_free;
  logic [11:0]                   rem_sh;
  logic                          div_ge;
  logic [6:0]                    bit_idx;
  logic                          any_cur;
  logic [63:0]                   energy_add;
  logic [48:0]                   env_sq_r;
  logic [23:0]                   mul_a, mul_b;

  assign out_free   = !out_valid || out_ready;
  assign rem_sh     = {div_rem, ms[slm_pkg::SUM_W-1]};
  assign div_ge     = (rem_sh >= {1'b0, e.len});
  assign bit_idx    = 7'd92 - 7'(thr_idx);
  assign any_cur    = ((thr_idx == '0) ? (|sq96[95:93]) : any_hi) | sq96[bit_idx];
  assign energy_add = {1'b0, energy} + 64'(ms);
  assign env_sq_r   = sq96[95:48] + 49'(sq96[47]);
  assign lvl_sum    = {1'b0, tmp} + {1'b0, mac_res};
  assign lvl_new    = slm_pkg::sat47(lvl_sum);
  assign imp_new    = (rise_run > imp_run) ? rise_run
                                           : slm_pkg::sat47({1'b0, mac_res});

  // envelope square digits: low*low, low*high, high*high
  always_comb begin
    unique case (esq_ph)
      2'd0:    begin mul_a = e.env_out[23:0];  mul_b = e.env_out[23:0];  end
      2'd1:    begin mul_a = e.env_out[23:0];  mul_b = e.env_out[47:24]; end
      default: begin mul_a = e.env_out[47:24]; mul_b = e.env_out[47:24]; end
    endcase
  end

  slm_mac u_mac (
    .clk   (clk),
    .rst   (rst),
    .start (mac_start),
    .v     (mac_v),
    .c     (mac_c),
    .done  (mac_done),
    .res   (mac_res)
  );

  always_comb begin
    st_next   = st;
    pop       = 1'b0;
    mac_start = 1'b0;
    mac_v     = ms;
    mac_c     = {1'b0, cfg.fast_coef};
    unique case (st)
      slm_pkg::B_IDLE: begin
        if (!q_empty) begin
          pop     = 1'b1;
          st_next = pop_data.has_step ? slm_pkg::B_DIV : slm_pkg::B_CNT_OUT;
        end
      end
      slm_pkg::B_DIV: if (div_cnt == 6'(slm_pkg::SUM_W - 1)) st_next = slm_pkg::B_ESQ;
      slm_pkg::B_ESQ: if (esq_ph == 2'd3) st_next = slm_pkg::B_THR;
      slm_pkg::B_THR: if (thr_idx == IDX_LAST) st_next = slm_pkg::B_FAST_X;
      slm_pkg::B_FAST_X: begin
        mac_start = !mac_pend;
        if (mac_done) st_next = slm_pkg::B_FAST_R;
      end
      slm_pkg::B_FAST_R: begin
        mac_v     = slm_pkg::SUM_W'(fast_run);
        mac_c     = slm_pkg::coef_b(cfg.fast_coef);
        mac_start = !mac_pend;
        if (mac_done) st_next = slm_pkg::B_SLOW_X;
      end
      slm_pkg::B_SLOW_X: begin
        mac_c     = {1'b0, cfg.slow_coef};
        mac_start = !mac_pend;
        if (mac_done) st_next = slm_pkg::B_SLOW_R;
      end
      slm_pkg::B_SLOW_R: begin
        mac_v     = slm_pkg::SUM_W'(slow_run);
        mac_c     = slm_pkg::coef_b(cfg.slow_coef);
        mac_start = !mac_pend;
        if (mac_done) st_next = slm_pkg::B_RISE_X;
      end
      slm_pkg::B_RISE_X: begin
        mac_c     = {1'b0, cfg.rise_coef};
        mac_start = !mac_pend;
        if (mac_done) st_next = slm_pkg::B_RISE_R;
      end
      slm_pkg::B_RISE_R: begin
        mac_v     = slm_pkg::SUM_W'(rise_run);
        mac_c     = slm_pkg::coef_b(cfg.rise_coef);
        mac_start = !mac_pend;
        if (mac_done) st_next = slm_pkg::B_IMP;
      end
      slm_pkg::B_IMP: begin
        mac_v     = slm_pkg::SUM_W'(imp_run);
        mac_c     = slm_pkg::coef_b(cfg.fall_coef);
        mac_start = !mac_pend;
        if (mac_done) st_next = slm_pkg::B_STEP_OUT;
      end
      slm_pkg::B_STEP_OUT: begin
        if (out_free) st_next = e.eot ? slm_pkg::B_CNT_OUT : slm_pkg::B_IDLE;
      end
      slm_pkg::B_CNT_OUT: begin
        if (out_free && thr_idx == IDX_LAST) st_next = slm_pkg::B_SUM_OUT;
      end
      slm_pkg::B_SUM_OUT: if (out_free) st_next = slm_pkg::B_IDLE;
      default: st_next = slm_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= slm_pkg::B_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mac_pend       <= 1'b0;
      out_valid      <= 1'b0;
      fast_run       <= '0;
      slow_run       <= '0;
      rise_run       <= '0;
      imp_run        <= '0;
      fast_peak      <= '0;
      slow_peak      <= '0;
      imp_peak       <= '0;
      mean_peak      <= '0;
      fast_peak_step <= '0;
      step_number    <= '0;
      energy         <= '0;
      for (int t = 0; t < NUM_THRESHOLDS; t++) begin
        active[t] <= '0;
        hang[t]   <= slm_pkg::RST_HANGOVER;
      end
    end else begin
      if (mac_start) mac_pend <= 1'b1;
      if (mac_done)  mac_pend <= 1'b0;
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (st)
        slm_pkg::B_IDLE: begin
          if (!q_empty) begin
            e       <= pop_data;
            ms      <= pop_data.square_sum;
            div_rem <= '0;
            div_cnt <= '0;
            esq_ph  <= '0;
            thr_idx <= '0;
          end
        end
        slm_pkg::B_DIV: begin
          // one quotient bit a cycle, shifted in where the dividend leaves
          div_rem <= div_ge ? slm_pkg::STEP_LEN_W'(rem_sh - {1'b0, e.len})
                            : rem_sh[slm_pkg::STEP_LEN_W-1:0];
          ms      <= {ms[slm_pkg::SUM_W-2:0], div_ge};
          div_cnt <= div_cnt + 6'd1;
        end
        slm_pkg::B_ESQ: begin
          mprod  <= mul_a * mul_b;
          esq_ph <= esq_ph + 2'd1;
          unique case (esq_ph)
            2'd0: begin
              energy <= energy_add[63] ? '1 : energy_add[slm_pkg::ENERGY_W-1:0];
              if (ms > mean_peak) mean_peak <= ms;
            end
            2'd1:    sq96 <= {48'd0, mprod};
            2'd2:    sq96 <= sq96 + {23'd0, mprod, 25'd0};
            default: sq96 <= sq96 + {mprod, 48'd0};
          endcase
        end
        slm_pkg::B_THR: begin
          any_hi <= any_cur;
          if (!any_cur) begin
            if (hang[thr_idx] < cfg.hangover) begin
              if (active[thr_idx] != '1) active[thr_idx] <= active[thr_idx] + 32'd1;
              hang[thr_idx] <= hang[thr_idx] + 10'd1;
            end
          end else begin
            if (active[thr_idx] != '1) active[thr_idx] <= active[thr_idx] + 32'd1;
            hang[thr_idx] <= '0;
          end
          thr_idx <= (thr_idx == IDX_LAST) ? '0 : thr_idx + IDX_W'(1);
        end
        slm_pkg::B_FAST_X, slm_pkg::B_SLOW_X, slm_pkg::B_RISE_X: begin
          if (mac_done) tmp <= mac_res;
        end
        slm_pkg::B_FAST_R: if (mac_done) fast_run <= lvl_new;
        slm_pkg::B_SLOW_R: if (mac_done) slow_run <= lvl_new;
        slm_pkg::B_RISE_R: if (mac_done) rise_run <= lvl_new;
        slm_pkg::B_IMP: begin
          if (mac_done) begin
            imp_run <= imp_new;
            if (fast_run > fast_peak) begin
              fast_peak      <= fast_run;
              fast_peak_step <= step_number;
            end
            if (slow_run > slow_peak) slow_peak <= slow_run;
            if (imp_new > imp_peak)   imp_peak  <= imp_new;
          end
        end
        slm_pkg::B_STEP_OUT: begin
          if (out_free) begin
            out_valid              <= 1'b1;
            out_data               <= '0;
            out_data.kind          <= slm_pkg::KIND_STEP;
            out_data.last          <= !e.eot;
            out_data.peak_sq       <= e.block_peak;
            out_data.mean_sq       <= ms[slm_pkg::LEVEL_W-1:0];
            out_data.envelope_sq   <= slm_pkg::sat47({2'd0, env_sq_r});
            out_data.fast_level    <= fast_run;
            out_data.slow_level    <= slow_run;
            out_data.impulse_level <= imp_run;
            out_data.index         <= step_number;
            out_data.total_energy  <= energy;
            if (step_number != '1) step_number <= step_number + 32'd1;
            thr_idx <= '0;
          end
        end
        slm_pkg::B_CNT_OUT: begin
          if (out_free) begin
            out_valid             <= 1'b1;
            out_data              <= '0;
            out_data.kind         <= slm_pkg::KIND_COUNT;
            out_data.index        <= 32'(thr_idx) + 32'd1;
            out_data.over_count   <= active[thr_idx];
            out_data.total_energy <= energy;
            thr_idx <= (thr_idx == IDX_LAST) ? '0 : thr_idx + IDX_W'(1);
          end
        end
        slm_pkg::B_SUM_OUT: begin
          if (out_free) begin
            out_valid              <= 1'b1;
            out_data               <= '0;
            out_data.kind          <= slm_pkg::KIND_SUMMARY;
            out_data.last          <= 1'b1;
            out_data.peak_sq       <= e.overall_peak;
            out_data.mean_sq       <= mean_peak[slm_pkg::LEVEL_W-1:0];
            out_data.fast_level    <= fast_peak;
            out_data.slow_level    <= slow_peak;
            out_data.impulse_level <= imp_peak;
            out_data.index         <= fast_peak_step;
            out_data.over_count    <= step_number;
            out_data.total_energy  <= energy;
            // track ends: drop all running state
            fast_run       <= '0;
            slow_run       <= '0;
            rise_run       <= '0;
            imp_run        <= '0;
            fast_peak      <= '0;
            slow_peak      <= '0;
            imp_peak       <= '0;
            mean_peak      <= '0;
            fast_peak_step <= '0;
            step_number    <= '0;
            energy         <= '0;
            for (int t = 0; t < NUM_THRESHOLDS; t++) begin
              active[t] <= '0;
              hang[t]   <= cfg.hangover;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/sound_level_meter_p56_unit.sv =====
// Sound level meter top: the front takes a new sample only when done with the
// last (square plus four envelope products through one shared 24x25
// multiplier). A finished block then passes through the back (bit-serial mean
// division, threshold walk of one counter a cycle, seven smoothing products);
// end of track adds one result per threshold plus the summary. Synchronous
// reset loads register defaults and clears all track state.
module sound_level_meter_p56_unit #(
  parameter int NUM_THRESHOLDS = slm_pkg::NUM_THRESHOLDS_DEF,
  parameter int Q_DEPTH        = slm_pkg::Q_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  slm_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output slm_pkg::out_item_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [slm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [slm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [slm_pkg::STEP_LEN_W-1:0] step_len;
  slm_pkg::cfg_t                  cfg;
  logic                           q_push, q_full, q_pop, q_empty;
  slm_pkg::q_entry_t              q_in, q_out;

  assign cfg_ready = 1'b1;

  // zero counts as one, long steps clamp
  always_comb begin
    if (step_len == '0) begin
      cfg.len = slm_pkg::STEP_LEN_W'(1);
    end else if (step_len > slm_pkg::STEP_LEN_W'(slm_pkg::MAX_STEP_LEN)) begin
      cfg.len = slm_pkg::STEP_LEN_W'(slm_pkg::MAX_STEP_LEN);
    end else begin
      cfg.len = step_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_len      <= slm_pkg::RST_STEP_LEN;
      cfg.env_coef  <= slm_pkg::RST_ENV_COEF;
      cfg.fast_coef <= slm_pkg::RST_FAST_COEF;
      cfg.slow_coef <= slm_pkg::RST_SLOW_COEF;
      cfg.rise_coef <= slm_pkg::RST_RISE_COEF;
      cfg.fall_coef <= slm_pkg::RST_FALL_COEF;
      cfg.hangover  <= slm_pkg::RST_HANGOVER;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        slm_pkg::CFG_STEP_LEN:  step_len      <= cfg_data[slm_pkg::STEP_LEN_W-1:0];
        slm_pkg::CFG_ENV_COEF:  cfg.env_coef  <= cfg_data;
        slm_pkg::CFG_FAST_COEF: cfg.fast_coef <= cfg_data;
        slm_pkg::CFG_SLOW_COEF: cfg.slow_coef <= cfg_data;
        slm_pkg::CFG_RISE_COEF: cfg.rise_coef <= cfg_data;
        slm_pkg::CFG_FALL_COEF: cfg.fall_coef <= cfg_data;
        slm_pkg::CFG_HANGOVER:  cfg.hangover  <= cfg_data[slm_pkg::HANG_W-1:0];
        default: ;
      endcase
    end
  end

  slm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg       (cfg),
    .push      (q_push),
    .push_data (q_in),
    .q_full    (q_full)
  );

  slm_fifo #(.DEPTH(Q_DEPTH)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  slm_back #(.NUM_THRESHOLDS(NUM_THRESHOLDS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .pop_data  (q_out),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== hw/rtl/slm_chk.sv =====
// Port-level checks for the sound level meter, bound to the top level.
// Depends on slm_pkg.
module slm_chk (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input slm_pkg::in_item_t              in_data,
  input logic                           out_valid,
  input logic                           out_ready,
  input slm_pkg::out_item_t             out_data,
  input logic                           cfg_valid,
  input logic                           cfg_ready,
  input logic [slm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [slm_pkg::CFG_DATA_W-1:0] cfg_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_count_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == slm_pkg::KIND_COUNT |->
      !out_data.last && out_data.index != '0 && out_data.fast_level == '0)
    else $error("bad threshold count result");

  a_summary_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == slm_pkg::KIND_SUMMARY |->
      out_data.last && out_data.envelope_sq == '0)
    else $error("bad summary result");

  // a taken threshold count is never directly followed by a step result
  a_summary_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_data.kind == slm_pkg::KIND_COUNT && !out_data.last
      |=> !(out_valid && out_data.kind == slm_pkg::KIND_STEP))
    else $error("step result inside count sequence");

endmodule

bind sound_level_meter_p56_unit slm_chk u_chk (.*);
